/* sv/crc_pkg.sv */
// crc_pkg: widths, register codes, word types and back-end states shared by
// the counter rate calculator modules. Depends on nothing.

package crc_pkg;

	// field widths
	localparam int TIME_W   = 48;
	localparam int VAL_W    = 40;
	localparam int LIM_W    = 40;
	localparam int RATE_W   = 64;
	localparam int FRAC_W   = 8;

	// value delta before and after the wrap correction
	localparam int DLT_W    = VAL_W + 1;
	localparam int WDL_W    = VAL_W + 2;

	// scaled numerator, dividend and quotient
	localparam int NUM_W    = 52;
	localparam int QUO_W    = NUM_W + FRAC_W;
	localparam int CNT_W    = $clog2(QUO_W);
	localparam int MS_SCALE = 1000;

	// job queue
	localparam int QDEPTH   = 2;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	// configuration port
	localparam int CFG_DW   = 64;
	localparam int ADDR_W   = 6;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_COUNTER_MODE = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DROP_WRAPS   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_COUNTER_LIM  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WRAP_THRESH  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MS_STAMPS    = 3'd4;

	typedef struct packed {
		logic                     counter_mode;
		logic                     drop_wraps;
		logic [LIM_W-1:0]         counter_limit;
		logic [LIM_W-1:0]         wrap_rate_threshold;
		logic                     millisecond_stamps;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]        sample_time;
		logic signed [VAL_W-1:0]  sample_value;
		logic                     series_start;
	} in_word_t;

	typedef struct packed {
		logic [TIME_W-1:0]        rate_time;
		logic signed [RATE_W-1:0] rate_value;
		logic                     wrapped;
		logic                     suppressed;
		logic                     order_error;
	} out_word_t;

	// one classified sample waiting for its division
	typedef struct packed {
		logic [TIME_W-1:0]        stamp;
		logic [TIME_W-1:0]        dt;
		logic [NUM_W-1:0]         num;
		logic                     neg;
		logic                     wrap;
		logic                     err;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

/* sv/counter_rate_calculator_top.sv */
// counter_rate_calculator_top: per-second rate of a timestamped counter series.
// Depends on crc_pkg, crc_regs, crc_front, crc_queue and crc_back.
//
// Input channel: sample_valid / sample_stall carry one sample word (time, value,
// series start). Output channel: rate_valid / rate_stall carry one rate word.
// A word moves on a rising edge with valid high and stall low.
// The first sample of a series, and a wrapped sample while drop_wraps is set,
// give no rate word; every other sample gives exactly one.
// The front takes one sample a cycle while its two stages and the two-entry job
// queue have room. The back divides one job at a time with a one-bit-per-cycle
// restoring divider over 60 quotient bits; each rate word takes a pop, 60
// division steps and a result, while an order error skips the steps.
// A stalled rate word holds in the output register while the back starts the
// next division; when queue and stages fill, sample_stall rises.
// Reset (arst_n low) clears the registers, the stored sample, the queue and
// all valids. Configuration is written through the APB port at 8*index,
// pready is always high; write it only while the block is idle.

module counter_rate_calculator_top
	import crc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  in_word_t          sample,
	output logic              rate_valid,
	input  logic              rate_stall,
	output out_word_t         rate,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t cfg;
	logic push;
	logic q_full;
	job_t push_job;
	logic pop;
	logic q_empty;
	job_t head;

	crc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.push         (push),
		.q_full       (q_full),
		.push_job     (push_job)
	);

	crc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	crc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.rate_valid (rate_valid),
		.rate_stall (rate_stall),
		.rate       (rate)
	);

endmodule

/* sv/crc_regs.sv */
// crc_regs: APB-style configuration register file, registers at 8*index.
// Depends on crc_pkg.

module crc_regs
	import crc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t                 cfg_q;
	logic                 wr_en;
	logic [REG_IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	// register writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_COUNTER_MODE: cfg_q.counter_mode        <= pwdata[0];
				REG_DROP_WRAPS:   cfg_q.drop_wraps          <= pwdata[0];
				REG_COUNTER_LIM:  cfg_q.counter_limit       <= pwdata[LIM_W-1:0];
				REG_WRAP_THRESH:  cfg_q.wrap_rate_threshold <= pwdata[LIM_W-1:0];
				REG_MS_STAMPS:    cfg_q.millisecond_stamps  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_COUNTER_MODE: prdata = CFG_DW'(cfg_q.counter_mode);
			REG_DROP_WRAPS:   prdata = CFG_DW'(cfg_q.drop_wraps);
			REG_COUNTER_LIM:  prdata = CFG_DW'(cfg_q.counter_limit);
			REG_WRAP_THRESH:  prdata = CFG_DW'(cfg_q.wrap_rate_threshold);
			REG_MS_STAMPS:    prdata = CFG_DW'(cfg_q.millisecond_stamps);
			default:          prdata = '0;
		endcase
	end

endmodule

/* sv/crc_front.sv */
// crc_front: accepts samples, keeps the previous sample, classifies each one
// and builds the scaled numerator over two stages. Depends on crc_pkg.

module crc_front
	import crc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     sample_valid,
	output logic     sample_stall,
	input  in_word_t sample,
	output logic     push,
	input  logic     q_full,
	output job_t     push_job
);

	logic [TIME_W-1:0]       prev_time_q;
	logic signed [VAL_W-1:0] prev_value_q;
	logic                    have_prev_q;

	logic                    s1_v_q;
	logic [TIME_W-1:0]       stamp_s1;
	logic [TIME_W-1:0]       dt_s1;
	logic signed [DLT_W-1:0] delta_s1;
	logic                    wrap_s1;
	logic                    err_s1;

	logic                    s2_v_q;
	logic [TIME_W-1:0]       stamp_s2;
	logic [TIME_W-1:0]       dt_s2;
	logic signed [WDL_W-1:0] delta_s2;
	logic                    wrap_s2;
	logic                    err_s2;

	logic                    acc;
	logic                    s1_move;
	logic                    s2_move;
	logic signed [DLT_W-1:0] delta_in;
	logic                    order_err;
	logic                    wrap_in;
	logic                    emit;
	logic signed [WDL_W-1:0] delta_wr;
	logic [WDL_W-1:0]        mag;
	logic                    neg;

	// stage handshakes
	assign s2_move      = s2_v_q && !q_full;
	assign s1_move      = s1_v_q && (!s2_v_q || s2_move);
	assign sample_stall = s1_v_q && !s1_move;
	assign acc          = sample_valid && !sample_stall;

	// classification of the incoming word against the stored sample
	assign delta_in  = DLT_W'(sample.sample_value) - DLT_W'(prev_value_q);
	assign order_err = !(sample.sample_time > prev_time_q);
	assign wrap_in   = cfg.counter_mode && delta_in[DLT_W-1] && !order_err;
	assign emit      = !sample.series_start && have_prev_q && !(wrap_in && cfg.drop_wraps);

	// previous sample, stored on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q  <= '0;
			prev_value_q <= '0;
			have_prev_q  <= 1'b0;
		end else if (acc) begin
			prev_time_q  <= sample.sample_time;
			prev_value_q <= sample.sample_value;
			have_prev_q  <= 1'b1;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
			s2_v_q <= 1'b0;
		end else begin
			if (acc)
				s1_v_q <= emit;
			else if (s1_move)
				s1_v_q <= 1'b0;
			if (s1_move)
				s2_v_q <= 1'b1;
			else if (s2_move)
				s2_v_q <= 1'b0;
		end
	end

	// stage 1: time delta and raw value delta
	always_ff @(posedge clk) begin
		if (acc) begin
			stamp_s1 <= sample.sample_time;
			dt_s1    <= sample.sample_time - prev_time_q;
			delta_s1 <= delta_in;
			wrap_s1  <= wrap_in;
			err_s1   <= order_err;
		end
	end

	// stage 2: wrap correction
	assign delta_wr = wrap_s1 ? WDL_W'(cfg.counter_limit) + WDL_W'(delta_s1)
	                          : WDL_W'(delta_s1);

	always_ff @(posedge clk) begin
		if (s1_move) begin
			stamp_s2 <= stamp_s1;
			dt_s2    <= dt_s1;
			delta_s2 <= delta_wr;
			wrap_s2  <= wrap_s1;
			err_s2   <= err_s1;
		end
	end

	// magnitude and millisecond scaling into the queue
	assign neg = delta_s2[WDL_W-1];
	assign mag = neg ? WDL_W'(-delta_s2) : WDL_W'(delta_s2);

	always_comb begin
		push_job.stamp = stamp_s2;
		push_job.dt    = dt_s2;
		push_job.num   = cfg.millisecond_stamps ? NUM_W'(NUM_W'(mag) * NUM_W'(MS_SCALE))
		                                        : NUM_W'(mag);
		push_job.neg   = neg;
		push_job.wrap  = wrap_s2;
		push_job.err   = err_s2;
	end

	assign push = s2_move;

endmodule

/* sv/crc_queue.sv */
// crc_queue: short FIFO of classified jobs between front and back.
// Depends on crc_pkg.

module crc_queue
	import crc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	output logic full,
	input  logic pop,
	output logic empty,
	output job_t head
);

	job_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = slot_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_job;
	end

endmodule

/* sv/crc_back.sv */
// crc_back: radix-2 restoring divider, threshold check and result register.
// Depends on crc_pkg.

module crc_back
	import crc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	input  job_t      head,
	output logic      pop,
	output logic      rate_valid,
	input  logic      rate_stall,
	output out_word_t rate
);

	back_state_t       state_q;
	back_state_t       state_d;
	job_t              job_q;
	logic [TIME_W-1:0] rem_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_v_q;
	out_word_t         out_q;

	logic              load;
	logic              step;
	logic              emit;
	logic              out_free;
	logic [TIME_W:0]   trial;
	logic              q_bit;
	logic [QUO_W-1:0]  thr_sh;
	logic              supp;
	logic [RATE_W-1:0] qx;
	out_word_t         res;

	assign out_free = !out_v_q || !rate_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= BK_IDLE;
		else
			state_q <= state_d;
	end

	// next state and controls
	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		emit    = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!q_empty) begin
					load    = 1'b1;
					state_d = head.err ? BK_DONE : BK_DIV;
				end
			end
			BK_DIV: begin
				step = 1'b1;
				if (cnt_q == '0)
					state_d = BK_DONE;
			end
			BK_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	assign pop = load;

	// one quotient bit per cycle
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign q_bit = (trial >= {1'b0, job_q.dt});

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= head;
			rem_q <= '0;
			quo_q <= head.err ? '0 : {head.num, FRAC_W'(0)};
			cnt_q <= CNT_W'(QUO_W - 1);
		end else if (step) begin
			rem_q <= q_bit ? TIME_W'(trial - {1'b0, job_q.dt}) : TIME_W'(trial);
			quo_q <= {quo_q[QUO_W-2:0], q_bit};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// threshold: true quotient above threshold, read from the scaled quotient
	assign thr_sh = QUO_W'({cfg.wrap_rate_threshold, FRAC_W'(0)});
	assign supp   = job_q.wrap && !job_q.neg && (cfg.wrap_rate_threshold != '0) &&
	                ((quo_q > thr_sh) || ((quo_q == thr_sh) && (rem_q != '0)));
	assign qx     = RATE_W'(quo_q);

	always_comb begin
		res.rate_time   = job_q.stamp;
		res.rate_value  = '0;
		res.wrapped     = 1'b0;
		res.suppressed  = 1'b0;
		res.order_error = 1'b0;
		if (job_q.err) begin
			res.order_error = 1'b1;
		end else begin
			res.wrapped    = job_q.wrap;
			res.suppressed = supp;
			if (!supp)
				res.rate_value = job_q.neg ? -qx : qx;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (emit)
			out_v_q <= 1'b1;
		else if (!rate_stall)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res;
	end

	assign rate_valid = out_v_q;
	assign rate       = out_q;

endmodule

/* sv/crc_checker.sv */
// crc_checker: port-level checks on the rate channel of the top level,
// attached by bind. Depends on crc_pkg and counter_rate_calculator_top.

module crc_checker
	import crc_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      rate_valid,
	input logic      rate_stall,
	input out_word_t rate
);

	// a stalled rate word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rate_valid && rate_stall |=> rate_valid && $stable(rate))
		else $error("rate word changed while stalled");

	// an order error carries a zero rate and no other flag
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		rate_valid && rate.order_error |->
			rate.rate_value == '0 && !rate.wrapped && !rate.suppressed)
		else $error("order error word not clean");

	// suppression only follows a wrap and zeroes the rate
	a_supp: assert property (@(posedge clk) disable iff (!arst_n)
		rate_valid && rate.suppressed |-> rate.wrapped && rate.rate_value == '0)
		else $error("suppressed word without wrap or with nonzero rate");

	// no rate word during reset
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !rate_valid)
		else $error("rate_valid high in reset");

endmodule

bind counter_rate_calculator_top crc_checker u_crc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rate_valid (rate_valid),
	.rate_stall (rate_stall),
	.rate       (rate)
);

/* bench/counter_rate_calculator_top_tb.sv */
// counter_rate_calculator_top_tb: self-checking bench for the counter rate calculator.
// Depends on crc_pkg and counter_rate_calculator_top; a scoreboard class predicts
// each rate word from accepted samples while plain tasks drive samples and APB writes.

module counter_rate_calculator_top_tb;
	import crc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam logic [CFG_DW-1:0] MAX40 = 64'h00FF_FFFF_FFFF;
	localparam logic [TIME_W-1:0] MAX48 = 48'hFFFF_FFFF_FFFF;

	// rate predictor and store of awaited rate words
	class rate_scoreboard;
		cfg_t regs = '0;
		logic [TIME_W-1:0] last_time = '0;
		logic signed [VAL_W-1:0] last_value = '0;
		bit have_last = 1'b0;
		out_word_t awaited[$];
		int unsigned fails = 0;

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
			case (idx)
				REG_COUNTER_MODE: regs.counter_mode = val[0];
				REG_DROP_WRAPS:   regs.drop_wraps = val[0];
				REG_COUNTER_LIM:  regs.counter_limit = val[LIM_W-1:0];
				REG_WRAP_THRESH:  regs.wrap_rate_threshold = val[LIM_W-1:0];
				REG_MS_STAMPS:    regs.millisecond_stamps = val[0];
				default: ;
			endcase
		endfunction

		// work out the rate word (if any) caused by one accepted sample
		function void note_sample(in_word_t w);
			logic [TIME_W-1:0] t0;
			longint v0, v1, delta;
			bit [63:0] mag, num, dt, quo;
			bit had, wrap, supp, neg;
			out_word_t r;
			t0 = last_time;
			v0 = longint'(last_value);
			v1 = longint'(w.sample_value);
			had = have_last;
			last_time = w.sample_time;
			last_value = w.sample_value;
			have_last = 1'b1;
			if (w.series_start || !had)
				return;
			r = '0;
			r.rate_time = w.sample_time;
			// timestamp not moving forward: flagged zero
			if (w.sample_time <= t0) begin
				r.order_error = 1'b1;
				awaited.push_back(r);
				return;
			end
			dt = 64'(w.sample_time - t0);
			delta = v1 - v0;
			wrap = 1'b0;
			supp = 1'b0;
			// negative delta in counter mode: assume the counter wrapped
			if (regs.counter_mode && delta < 0) begin
				if (regs.drop_wraps)
					return;
				wrap = 1'b1;
				delta = longint'({24'd0, regs.counter_limit}) + v1 - v0;
			end
			neg = delta < 0;
			mag = neg ? -delta : delta;
			num = regs.millisecond_stamps ? mag * MS_SCALE : mag;
			// exact threshold test on the integer quotient and remainder
			if (wrap && !neg && regs.wrap_rate_threshold != 0) begin
				quo = num / dt;
				if (quo > regs.wrap_rate_threshold ||
						(quo == regs.wrap_rate_threshold && (num % dt) != 0))
					supp = 1'b1;
			end
			if (!supp) begin
				quo = (num << FRAC_W) / dt;
				r.rate_value = neg ? -quo : quo;
			end
			r.wrapped = wrap;
			r.suppressed = supp;
			awaited.push_back(r);
		endfunction

		function void field_check(string name, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				fails++;
				$display("%0t: %s expected %h got %h", $time, name, want, got);
			end
		endfunction

		// compare one accepted rate word with the oldest awaited one
		function void check_rate(out_word_t got);
			out_word_t want;
			if (awaited.size() == 0) begin
				fails++;
				$display("%0t: unexpected rate word, expected none got %h", $time, got);
				return;
			end
			want = awaited.pop_front();
			field_check("rate_time", 64'(want.rate_time), 64'(got.rate_time));
			field_check("rate_value", want.rate_value, got.rate_value);
			field_check("wrapped", 64'(want.wrapped), 64'(got.wrapped));
			field_check("suppressed", 64'(want.suppressed), 64'(got.suppressed));
			field_check("order_error", 64'(want.order_error), 64'(got.order_error));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic sample_valid = 1'b0;
	logic sample_stall;
	in_word_t sample = '0;
	logic rate_valid;
	logic rate_stall = 1'b0;
	out_word_t rate;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [CFG_DW-1:0] pwdata = '0;
	logic [CFG_DW-1:0] prdata;
	logic pready;

	rate_scoreboard sb = new();

	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_cycles = 0;
	int unsigned cycle_count = 0;

	// state of the sample series generator
	logic [TIME_W-1:0] run_time = '0;
	logic [VAL_W-1:0] run_value = '0;
	int unsigned run_left = 0;
	int unsigned run_bits = 8;

	counter_rate_calculator_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.rate_valid(rate_valid),
		.rate_stall(rate_stall),
		.rate(rate),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// watch both channels at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall)
				sb.note_sample(sample);
			if (rate_valid && !rate_stall)
				sb.check_rate(rate);
		end
	end

	// receiver: long hold-off when asked, else random stalls
	always @(negedge clk) begin
		if (hold_cycles != 0) begin
			rate_stall = 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rate_stall = (stall_pct != 0) && ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [63:0] rand_bits(int unsigned n);
		logic [63:0] x;
		x = {$urandom, $urandom};
		return (n >= 64) ? x : (x & ((64'd1 << n) - 64'd1));
	endfunction

	function automatic in_word_t mk(logic [TIME_W-1:0] t, longint v, bit s);
		in_word_t w;
		w.sample_time = t;
		w.sample_value = v[VAL_W-1:0];
		w.series_start = s;
		return w;
	endfunction

	// APB write: setup cycle, then access cycle until pready
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_W'({idx, 3'b000});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic load_regs(input logic [CFG_DW-1:0] mode, input logic [CFG_DW-1:0] drop,
			input logic [CFG_DW-1:0] limit, input logic [CFG_DW-1:0] thresh,
			input logic [CFG_DW-1:0] ms);
		write_reg(REG_COUNTER_MODE, mode);
		write_reg(REG_DROP_WRAPS, drop);
		write_reg(REG_COUNTER_LIM, limit);
		write_reg(REG_WRAP_THRESH, thresh);
		write_reg(REG_MS_STAMPS, ms);
	endtask

	// offer one sample word; called and left just after a falling edge
	task automatic send_word(input in_word_t w);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			sample_valid = 1'b0;
			@(negedge clk);
		end
		sample = w;
		sample_valid = 1'b1;
		do @(posedge clk); while (sample_stall);
		@(negedge clk);
	endtask

	// let the block run dry before touching the registers
	task automatic settle();
		sample_valid = 1'b0;
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// mostly well-formed counter series, with wraps, reorderings and noise
	task automatic next_sample(output in_word_t w);
		int unsigned pick;
		pick = $urandom_range(99);
		w = '0;
		if (pick < 8) begin
			w.sample_time = TIME_W'(rand_bits(TIME_W));
			w.sample_value = VAL_W'(rand_bits(VAL_W));
			w.series_start = 1'($urandom_range(1));
			return;
		end
		if (run_left == 0 || pick < 12) begin
			run_left = $urandom_range(4, 40);
			run_bits = $urandom_range(3, 38);
			run_time = TIME_W'(rand_bits($urandom_range(8, TIME_W)));
			run_value = VAL_W'(rand_bits(run_bits));
			if ($urandom_range(3) == 0)
				run_value = -run_value;
			w.series_start = 1'b1;
		end else begin
			run_left--;
			pick = $urandom_range(99);
			if (pick < 4)
				run_time = run_time;
			else if (pick < 7)
				run_time = run_time - $urandom_range(1, 50);
			else if (pick < 15)
				run_time = TIME_W'(run_time + rand_bits(32) + 1);
			else
				run_time = run_time + $urandom_range(1, 1000);
			pick = $urandom_range(99);
			if (pick < 10)
				run_value = VAL_W'(rand_bits(run_bits));
			else if (pick < 15)
				run_value = VAL_W'(run_value - rand_bits(run_bits));
			else
				run_value = VAL_W'(run_value + rand_bits(run_bits - 2));
		end
		w.sample_time = run_time;
		w.sample_value = run_value;
	endtask

	task automatic run_phase(input int unsigned n, input int unsigned snd_idle,
			input int unsigned rcv_stall, input int unsigned hold);
		in_word_t w;
		idle_pct = snd_idle;
		stall_pct = rcv_stall;
		hold_cycles <= hold;
		repeat (n) begin
			next_sample(w);
			send_word(w);
		end
		settle();
	endtask

	initial begin
		#1 arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// plain rates in seconds: field extremes and ordering errors
		load_regs(0, 0, 0, 0, 0);
		send_word(mk(48'd0, 0, 1'b1));
		send_word(mk(48'd1, 549755813887, 1'b0));
		send_word(mk(MAX48, -549755813888, 1'b0));
		send_word(mk(MAX48, 0, 1'b0));
		send_word(mk(48'd7, 5, 1'b0));
		send_word(mk(48'd9, -3, 1'b0));
		send_word(mk(48'd10, 0, 1'b1));
		settle();

		// wrap against the largest limit, millisecond stamps
		load_regs(1, 0, MAX40, 0, 1);
		send_word(mk(48'd1000, 100, 1'b1));
		send_word(mk(48'd1003, 50, 1'b0));
		send_word(mk(48'd1004, 549755813887, 1'b0));
		settle();

		// threshold: exact quotient passes, above it is zeroed
		load_regs(1, 0, 1000, 200, 0);
		send_word(mk(48'd0, 900, 1'b1));
		send_word(mk(48'd1, 100, 1'b0));
		send_word(mk(48'd2, 0, 1'b0));
		send_word(mk(48'd5, -200, 1'b0));
		settle();

		// threshold equal to quotient with a remainder is still zeroed
		load_regs(1, 0, 1000, 266, 0);
		send_word(mk(48'd8, -400, 1'b0));
		send_word(mk(48'd11, -1002, 1'b0));
		settle();

		// zero limit gives a negative wrap delta, never above threshold
		load_regs(1, 0, 0, 266, 0);
		send_word(mk(48'd12, -1003, 1'b0));
		settle();

		// dropped wrap still becomes the previous sample
		load_regs(1, 1, 0, 0, 0);
		send_word(mk(48'd13, -1004, 1'b0));
		send_word(mk(48'd14, 0, 1'b0));
		send_word(mk(48'd20, 0, 1'b0));
		settle();

		// random series under several settings and idling patterns
		load_regs(0, 0, rand_bits(LIM_W), rand_bits(LIM_W), 0);
		run_phase(100, 0, 0, 0);
		load_regs(1, 0, MAX40, 0, 1);
		run_phase(100, 47, 0, 0);
		load_regs(1, 1, rand_bits(LIM_W), 1, 0);
		run_phase(100, 0, 47, 0);
		load_regs(1, 0, rand_bits(20), rand_bits(16) + 1, 1);
		run_phase(100, 21, 21, 600);
		load_regs(1, 0, 0, MAX40, 0);
		run_phase(100, 0, 0, 800);
		load_regs(1, 0, rand_bits(LIM_W), rand_bits($urandom_range(1, LIM_W)), 1);
		run_phase(100, 21, 21, 0);

		if (sb.fails == 0 && sb.awaited.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
